[hdl/rqt_pkg.sv]
// ----------------------------------------------------------------------------
// rqt_pkg
// shared types and constants of the quarter-turn frame rotator
// ----------------------------------------------------------------------------
`default_nettype none

package rqt_pkg;

    localparam int COLOR_W    = 8;
    localparam int PIX_W      = 3 * COLOR_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int TURNS_W    = 2;
    localparam int SIZE_W     = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_TURNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd2;

    localparam logic [TURNS_W-1:0] TURN_0   = 2'd0;
    localparam logic [TURNS_W-1:0] TURN_90  = 2'd1;
    localparam logic [TURNS_W-1:0] TURN_180 = 2'd2;
    localparam logic [TURNS_W-1:0] TURN_270 = 2'd3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    typedef struct packed {
        logic store;
        logic fetch;
        logic capture;
    } t_cmd;

    typedef struct packed {
        logic frame_full;
    } t_sts;

endpackage

`default_nettype wire

[hdl/rqt_pix_in_if.sv]
// ----------------------------------------------------------------------------
// rqt_pix_in_if
// input item channel: load or drain request with one rgb pixel
// ----------------------------------------------------------------------------
`default_nettype none

interface rqt_pix_in_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [rqt_pkg::COLOR_W-1:0] red_in;
    logic [rqt_pkg::COLOR_W-1:0] green_in;
    logic [rqt_pkg::COLOR_W-1:0] blue_in;

    modport source (output valid, output mode, output red_in, output green_in,
                    output blue_in, input ready);
    modport sink   (input valid, input mode, input red_in, input green_in,
                    input blue_in, output ready);
endinterface

`default_nettype wire

[hdl/rqt_pix_out_if.sv]
// ----------------------------------------------------------------------------
// rqt_pix_out_if
// output item channel: one rotated rgb pixel and the end of frame flag
// ----------------------------------------------------------------------------
`default_nettype none

interface rqt_pix_out_if;
    logic                         valid;
    logic                         ready;
    logic [rqt_pkg::COLOR_W-1:0] red_out;
    logic [rqt_pkg::COLOR_W-1:0] green_out;
    logic [rqt_pkg::COLOR_W-1:0] blue_out;
    logic                         frame_end;

    modport source (output valid, output red_out, output green_out,
                    output blue_out, output frame_end, input ready);
    modport sink   (input valid, input red_out, input green_out,
                    input blue_out, input frame_end, output ready);
endinterface

`default_nettype wire

[hdl/rqt_cfg_if.sv]
// ----------------------------------------------------------------------------
// rqt_cfg_if
// register write channel: register index and write data
// ----------------------------------------------------------------------------
`default_nettype none

interface rqt_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rqt_pkg::CFG_IDX_W-1:0]  index;
    logic [rqt_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/rqt_ram.sv]
// ----------------------------------------------------------------------------
// rqt_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rqt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                        i_wr_data,
    input  wire logic                                    i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output      logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[hdl/rqt_ctrl.sv]
// ----------------------------------------------------------------------------
// rqt_ctrl
// controller: item handshake, buffer read sequencing and output valid
// ----------------------------------------------------------------------------
`default_nettype none

module rqt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_mode,
    output      logic          o_in_ready,
    output      logic          o_out_valid,
    input  wire logic          i_out_ready,
    input  wire rqt_pkg::t_sts i_sts,
    output      rqt_pkg::t_cmd o_cmd
);

    rqt_pkg::t_state r_state;
    rqt_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            accept;

    always_comb begin
        n_state = r_state;
        case (r_state)
            rqt_pkg::S_IDLE: begin
                if (o_cmd.fetch) begin
                    n_state = rqt_pkg::S_READ;
                end
            end
            rqt_pkg::S_READ: begin
                n_state = rqt_pkg::S_IDLE;
            end
            default: begin
                n_state = rqt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        case (r_state)
            rqt_pkg::S_IDLE: begin
                o_in_ready = !r_out_valid || i_out_ready;
            end
            rqt_pkg::S_READ: begin
                o_cmd.capture = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        accept      = i_in_valid && o_in_ready;
        o_cmd.store = accept && !i_in_mode && !i_sts.frame_full;
        o_cmd.fetch = accept && i_in_mode && i_sts.frame_full;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.capture) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rqt_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

[hdl/rqt_dp.sv]
// ----------------------------------------------------------------------------
// rqt_dp
// datapath: registers, frame buffer, load counter, drain position and
// rotated address, output pixel register
// ----------------------------------------------------------------------------
`default_nettype none

module rqt_dp #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    rqt_cfg_if.sink                           cfg,
    input  wire logic [rqt_pkg::COLOR_W-1:0] i_red,
    input  wire logic [rqt_pkg::COLOR_W-1:0] i_green,
    input  wire logic [rqt_pkg::COLOR_W-1:0] i_blue,
    input  wire rqt_pkg::t_cmd                i_cmd,
    output      rqt_pkg::t_sts                o_sts,
    output      logic [rqt_pkg::COLOR_W-1:0] o_red,
    output      logic [rqt_pkg::COLOR_W-1:0] o_green,
    output      logic [rqt_pkg::COLOR_W-1:0] o_blue,
    output      logic                         o_frame_end
);

    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int HW      = $clog2(MAX_HEIGHT + 1);
    localparam int DW      = $clog2(MAX_DIM + 1);
    localparam int PW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    logic [rqt_pkg::TURNS_W-1:0] r_turns, n_turns;
    logic [rqt_pkg::SIZE_W-1:0]  r_width, n_width;
    logic [rqt_pkg::SIZE_W-1:0]  r_height, n_height;
    logic [CW-1:0]               r_load_cnt, n_load_cnt;
    logic [PW-1:0]               r_row, n_row;
    logic [PW-1:0]               r_col, n_col;
    logic                        r_last_pend, n_last_pend;
    logic [rqt_pkg::COLOR_W-1:0] r_red, r_green, r_blue;
    logic                        r_frame_end;

    logic [WW-1:0]      w;
    logic [HW-1:0]      h;
    logic [WW+HW-1:0]   total;
    logic               swap;
    logic [DW-1:0]      out_w, out_h;
    logic [PW-1:0]      rr, cc;
    logic [DW-1:0]      rr_d, cc_d;
    logic [DW-1:0]      w_d, h_d;
    logic [DW-1:0]      sy, sx;
    logic [DW+WW-1:0]   addr_full;
    logic               row_end, last;
    logic               cfg_wr;
    logic [rqt_pkg::PIX_W-1:0] rd_data;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid;

    assign w = (r_width == '0) ? WW'(1) :
               ((32'(r_width) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(r_width));
    assign h = (r_height == '0) ? HW'(1) :
               ((32'(r_height) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(r_height));

    assign total            = w * h;
    assign o_sts.frame_full = 32'(r_load_cnt) >= 32'(total);

    assign w_d   = DW'(w);
    assign h_d   = DW'(h);
    assign swap  = (r_turns == rqt_pkg::TURN_90) || (r_turns == rqt_pkg::TURN_270);
    assign out_w = swap ? h_d : w_d;
    assign out_h = swap ? w_d : h_d;

    assign rr   = (DW'(r_row) >= out_h) ? PW'(out_h - DW'(1)) : r_row;
    assign cc   = (DW'(r_col) >= out_w) ? PW'(out_w - DW'(1)) : r_col;
    assign rr_d = DW'(rr);
    assign cc_d = DW'(cc);

    always_comb begin
        case (r_turns)
            rqt_pkg::TURN_90: begin
                sy = cc_d;
                sx = w_d - DW'(1) - rr_d;
            end
            rqt_pkg::TURN_180: begin
                sy = h_d - DW'(1) - rr_d;
                sx = w_d - DW'(1) - cc_d;
            end
            rqt_pkg::TURN_270: begin
                sy = h_d - DW'(1) - cc_d;
                sx = rr_d;
            end
            default: begin
                sy = rr_d;
                sx = cc_d;
            end
        endcase
    end

    assign addr_full = sy * w + sx;

    assign row_end = (cc_d == out_w - DW'(1));
    assign last    = (rr_d == out_h - DW'(1)) && row_end;

    rqt_ram #(
        .WIDTH (rqt_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.store),
        .i_wr_addr (r_load_cnt[AW-1:0]),
        .i_wr_data ({i_red, i_green, i_blue}),
        .i_rd_en   (i_cmd.fetch),
        .i_rd_addr (addr_full[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_turns     = r_turns;
        n_width     = r_width;
        n_height    = r_height;
        n_load_cnt  = r_load_cnt;
        n_row       = r_row;
        n_col       = r_col;
        n_last_pend = r_last_pend;
        if (i_cmd.store) begin
            n_load_cnt = r_load_cnt + CW'(1);
        end
        if (i_cmd.fetch) begin
            n_last_pend = last;
            if (last) begin
                n_load_cnt = '0;
                n_row      = '0;
                n_col      = '0;
            end else if (row_end) begin
                n_col = '0;
                n_row = PW'(rr_d + DW'(1));
            end else begin
                n_col = PW'(cc_d + DW'(1));
                n_row = rr;
            end
        end
        if (cfg_wr) begin
            case (cfg.index)
                rqt_pkg::CFG_QUARTER_TURNS: begin
                    n_turns    = cfg.data[rqt_pkg::TURNS_W-1:0];
                    n_load_cnt = '0;
                    n_row      = '0;
                    n_col      = '0;
                end
                rqt_pkg::CFG_IMAGE_WIDTH: begin
                    n_width    = cfg.data[rqt_pkg::SIZE_W-1:0];
                    n_load_cnt = '0;
                    n_row      = '0;
                    n_col      = '0;
                end
                rqt_pkg::CFG_IMAGE_HEIGHT: begin
                    n_height   = cfg.data[rqt_pkg::SIZE_W-1:0];
                    n_load_cnt = '0;
                    n_row      = '0;
                    n_col      = '0;
                end
                default: begin
                    n_turns = r_turns;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turns    <= rqt_pkg::TURN_0;
            r_width    <= rqt_pkg::SIZE_RESET;
            r_height   <= rqt_pkg::SIZE_RESET;
            r_load_cnt <= '0;
            r_row      <= '0;
            r_col      <= '0;
        end else begin
            r_turns    <= n_turns;
            r_width    <= n_width;
            r_height   <= n_height;
            r_load_cnt <= n_load_cnt;
            r_row      <= n_row;
            r_col      <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_pend <= n_last_pend;
        if (i_cmd.capture) begin
            r_red       <= rd_data[rqt_pkg::PIX_W-1 -: rqt_pkg::COLOR_W];
            r_green     <= rd_data[2*rqt_pkg::COLOR_W-1 -: rqt_pkg::COLOR_W];
            r_blue      <= rd_data[rqt_pkg::COLOR_W-1:0];
            r_frame_end <= r_last_pend;
        end
    end

    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;
    assign o_frame_end = r_frame_end;

endmodule

`default_nettype wire

[hdl/image_rotate_quarter_turns.sv]
// ----------------------------------------------------------------------------
// image_rotate_quarter_turns
// frame rotator by 0, 90, 180 or 270 degrees over an on-chip frame buffer
// ----------------------------------------------------------------------------
// Load items (mode 0) write pixels into the frame buffer in input row-major
// order until width times height pixels are held; further loads are dropped.
// Drain items (mode 1) each return one pixel of the rotated frame in its
// row-major order, with frame_end on the last one; drains before the frame
// is full give no item. After the last pixel, or after any register write,
// loading starts again at the first pixel. A drain reads the frame buffer
// through its registered read port, then the read state captures the pixel
// into the output register. While the rotated pixel waits in the output
// register no item is taken, except in the cycle in which the pixel leaves.
// Sizes of 0 count as 1 and sizes above MAX_WIDTH or MAX_HEIGHT saturate.
// Write registers only while no item is in flight; the block does not enforce this.
`default_nettype none

module image_rotate_quarter_turns #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    rqt_pix_in_if.sink    i_pix,
    rqt_pix_out_if.source o_pix,
    rqt_cfg_if.sink       i_cfg
);

    rqt_pkg::t_cmd cmd;
    rqt_pkg::t_sts sts;

    rqt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .i_in_mode   (i_pix.mode),
        .o_in_ready  (i_pix.ready),
        .o_out_valid (o_pix.valid),
        .i_out_ready (o_pix.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rqt_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .cfg         (i_cfg),
        .i_red       (i_pix.red_in),
        .i_green     (i_pix.green_in),
        .i_blue      (i_pix.blue_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_red       (o_pix.red_out),
        .o_green     (o_pix.green_out),
        .o_blue      (o_pix.blue_out),
        .o_frame_end (o_pix.frame_end)
    );

`ifndef SYNTH
    a_fetch_to_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fetch |=> (!o_pix.valid ##1 o_pix.valid))
        else $error("drain result not presented after buffer read");

    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && o_pix.ready && o_pix.frame_end
         && !(i_pix.valid && i_pix.ready)) |=> !sts.frame_full)
        else $error("frame still full after last pixel");

    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.valid && i_cfg.ready
         && (i_cfg.index == rqt_pkg::CFG_QUARTER_TURNS
             || i_cfg.index == rqt_pkg::CFG_IMAGE_WIDTH
             || i_cfg.index == rqt_pkg::CFG_IMAGE_HEIGHT)) |=> !sts.frame_full)
        else $error("register write did not restart the frame");
`endif

endmodule

`default_nettype wire
